### hw/rtl/morse_tone_decoder_unit_macros.svh
// assertion macros shared by the morse tone decoder rtl
`ifndef MORSE_TONE_DECODER_UNIT_MACROS_SVH
`define MORSE_TONE_DECODER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define MTD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define MTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MTD_ASSERT(lbl, clk, rstn, prop, msg)
`define MTD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/mtd_pkg.sv
// package: types, constants and the code table of the morse tone decoder
package mtd_pkg;

  localparam int CountBits  = 20;
  localparam int ThrBits    = 15;
  localparam int SampleBits = 16;
  localparam int CharBits   = 7;
  localparam int AddrBits   = 5;
  localparam int DataBits   = 32;
  localparam int QueueDepth = 4;
  localparam int QPtrBits   = $clog2(QueueDepth);
  localparam int QCntBits   = $clog2(QueueDepth + 1);

  localparam logic [CountBits-1:0] CntMax    = {CountBits{1'b1}};
  localparam logic [CharBits-1:0]  SpaceChar = 7'd32;
  localparam logic [2:0]           MaxLen    = 3'd5;
  localparam logic [2:0]           OvfLen    = 3'd6;

  localparam logic [ThrBits-1:0]   ThrReset     = 15'd13107;
  localparam logic [CountBits-1:0] MinPulseRst  = 20'd720;
  localparam logic [CountBits-1:0] DotMaxRst    = 20'd3360;
  localparam logic [CountBits-1:0] DashMaxRst   = 20'd10080;
  localparam logic [CountBits-1:0] GapLenRst    = 20'd10080;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_MIN_PULSE = 3'd1,
    REG_DOT_MAX   = 3'd2,
    REG_DASH_MAX  = 3'd3,
    REG_GAP_LEN   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [ThrBits-1:0]   tone_threshold;
    logic [CountBits-1:0] min_pulse;
    logic [CountBits-1:0] dot_max;
    logic [CountBits-1:0] dash_max;
    logic [CountBits-1:0] gap_len;
  } cfg_t;

  typedef struct packed {
    logic [CharBits-1:0] character;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [1:0]       cnt;
    result_t [1:0]    ent;
  } push_t;

  function automatic logic [CharBits-1:0] decode_code(input logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'd2:  c = "E";  6'd3:  c = "T";  6'd4:  c = "I";  6'd5:  c = "A";
      6'd6:  c = "N";  6'd7:  c = "M";  6'd8:  c = "S";  6'd9:  c = "U";
      6'd10: c = "R";  6'd11: c = "W";  6'd12: c = "D";  6'd13: c = "K";
      6'd14: c = "G";  6'd15: c = "O";  6'd16: c = "H";  6'd17: c = "V";
      6'd18: c = "F";  6'd20: c = "L";  6'd22: c = "P";  6'd23: c = "J";
      6'd24: c = "B";  6'd25: c = "X";  6'd26: c = "C";  6'd27: c = "Y";
      6'd28: c = "Z";  6'd29: c = "Q";  6'd32: c = "5";  6'd33: c = "4";
      6'd35: c = "3";  6'd39: c = "2";  6'd47: c = "1";  6'd48: c = "6";
      6'd56: c = "7";  6'd60: c = "8";  6'd62: c = "9";  6'd63: c = "0";
      default: c = 8'd0;
    endcase
    return c[CharBits-1:0];
  endfunction

endpackage

### hw/rtl/mtd_if.sv
// valid/ready channel interfaces for samples and decoded characters
interface mtd_in_if
  import mtd_pkg::*;
  ();
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mtd_out_if
  import mtd_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CharBits-1:0] character;
  logic                last;
  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

### hw/rtl/mtd_cfg.sv
// apb register block holding threshold and timing limits
module mtd_cfg
  import mtd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tone_threshold <= ThrReset;
      cfg_r.min_pulse      <= MinPulseRst;
      cfg_r.dot_max        <= DotMaxRst;
      cfg_r.dash_max       <= DashMaxRst;
      cfg_r.gap_len        <= GapLenRst;
    end else if (wr_en) begin
      unique case (paddr[AddrBits-1:2])
        REG_THRESHOLD: cfg_r.tone_threshold <= pwdata[ThrBits-1:0];
        REG_MIN_PULSE: cfg_r.min_pulse      <= pwdata[CountBits-1:0];
        REG_DOT_MAX:   cfg_r.dot_max        <= pwdata[CountBits-1:0];
        REG_DASH_MAX:  cfg_r.dash_max       <= pwdata[CountBits-1:0];
        REG_GAP_LEN:   cfg_r.gap_len        <= pwdata[CountBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[AddrBits-1:2])
      REG_THRESHOLD: prdata = DataBits'(cfg_r.tone_threshold);
      REG_MIN_PULSE: prdata = DataBits'(cfg_r.min_pulse);
      REG_DOT_MAX:   prdata = DataBits'(cfg_r.dot_max);
      REG_DASH_MAX:  prdata = DataBits'(cfg_r.dash_max);
      REG_GAP_LEN:   prdata = DataBits'(cfg_r.gap_len);
      default:       prdata = '0;
    endcase
  end

endmodule

### hw/rtl/mtd_core.sv
// sample register, tone and silence counters, pattern build and decode
`include "morse_tone_decoder_unit_macros.svh"
module mtd_core
  import mtd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mtd_in_if.sink    in_ch,
  input  cfg_t      cfg,
  input  logic      room,
  output push_t     push
);

  logic                         s_vld_r;
  logic signed [SampleBits-1:0] s_sample_r;
  logic                         in_tone_r, in_tone_nxt;
  logic [CountBits-1:0]         tone_cnt_r, tone_cnt_nxt;
  logic [CountBits-1:0]         sil_cnt_r, sil_cnt_nxt;
  logic [4:0]                   pbits_r, pbits_nxt;
  logic [2:0]                   plen_r, plen_nxt;

  logic                 fire;
  logic [SampleBits:0]  mag;
  logic                 is_tone;
  logic [CountBits-1:0] tone_inc, sil_inc;
  logic                 is_dot, is_dash;
  logic [5:0]           code_idx;
  logic [CharBits-1:0]  dec_char;

  assign fire        = s_vld_r && room;
  assign in_ch.ready = !s_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s_vld_r <= 1'b1;
    end else if (fire) begin
      s_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s_sample_r <= in_ch.sample;
    end
  end

  always_comb begin
    mag      = s_sample_r[SampleBits-1] ?
               ((SampleBits+1)'(1) << SampleBits) - {1'b0, s_sample_r} :
               {1'b0, s_sample_r};
    is_tone  = mag >= (SampleBits+1)'(cfg.tone_threshold);
    tone_inc = (tone_cnt_r == CntMax) ? tone_cnt_r : tone_cnt_r + CountBits'(1);
    sil_inc  = (sil_cnt_r == CntMax) ? sil_cnt_r : sil_cnt_r + CountBits'(1);
    is_dot   = (tone_cnt_r >= cfg.min_pulse) && (tone_cnt_r <= cfg.dot_max);
    is_dash  = (tone_cnt_r > cfg.dot_max) && (tone_cnt_r <= cfg.dash_max);
    code_idx = (6'd1 << plen_r) | {1'b0, pbits_r};
    dec_char = (plen_r > MaxLen) ? SpaceChar : decode_code(code_idx);
  end

  always_comb begin
    in_tone_nxt  = in_tone_r;
    tone_cnt_nxt = tone_cnt_r;
    sil_cnt_nxt  = sil_cnt_r;
    pbits_nxt    = pbits_r;
    plen_nxt     = plen_r;
    push.cnt     = 2'd0;
    push.ent[0]  = '{character: SpaceChar, last: 1'b1};
    push.ent[1]  = '{character: SpaceChar, last: 1'b1};
    if (fire) begin
      if (is_tone) begin
        in_tone_nxt  = 1'b1;
        tone_cnt_nxt = in_tone_r ? tone_inc : CountBits'(1);
      end else if (in_tone_r) begin
        if (is_dot || is_dash) begin
          if (plen_r < MaxLen) begin
            pbits_nxt = {pbits_r[3:0], is_dash};
            plen_nxt  = plen_r + 3'd1;
          end else begin
            plen_nxt = OvfLen;
          end
        end
        in_tone_nxt  = 1'b0;
        tone_cnt_nxt = '0;
        sil_cnt_nxt  = '0;
      end else begin
        sil_cnt_nxt = sil_inc;
        if (sil_inc >= cfg.gap_len) begin
          sil_cnt_nxt = '0;
          if (plen_r != 3'd0) begin
            push.cnt    = 2'd2;
            push.ent[0] = '{character: dec_char, last: 1'b0};
            pbits_nxt   = '0;
            plen_nxt    = '0;
          end else begin
            push.cnt = 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_tone_r  <= 1'b0;
      tone_cnt_r <= '0;
      sil_cnt_r  <= '0;
      pbits_r    <= '0;
      plen_r     <= '0;
    end else begin
      in_tone_r  <= in_tone_nxt;
      tone_cnt_r <= tone_cnt_nxt;
      sil_cnt_r  <= sil_cnt_nxt;
      pbits_r    <= pbits_nxt;
      plen_r     <= plen_nxt;
    end
  end

  `MTD_ASSERT(a_plen_range, clk, rst_n, plen_r != 3'd7, "pattern length out of range")
  `MTD_ASSERT(a_tone_cnt_idle, clk, rst_n, !in_tone_r |-> tone_cnt_r == '0, "tone count off tone")
  `MTD_ASSERT(a_pair_order, clk, rst_n, (push.cnt == 2'd2) |-> !push.ent[0].last, "pair order")

endmodule

### hw/rtl/mtd_outq.sv
// four entry result queue taking up to two results per cycle
`include "morse_tone_decoder_unit_macros.svh"
module mtd_outq
  import mtd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output logic      room,
  mtd_out_if.source out_ch
);

  result_t               mem_r [QueueDepth];
  logic [QPtrBits-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCntBits-1:0]   cnt_r, cnt_nxt;
  logic                  pop;
  logic [QPtrBits-1:0]   wr_ptr_p1;

  assign room             = cnt_r <= QCntBits'(QueueDepth - 2);
  assign pop              = out_ch.valid && out_ch.ready;
  assign out_ch.valid     = cnt_r != '0;
  assign out_ch.character = mem_r[rd_ptr_r].character;
  assign out_ch.last      = mem_r[rd_ptr_r].last;
  assign wr_ptr_p1        = wr_ptr_r + QPtrBits'(1);
  assign cnt_nxt          = cnt_r + QCntBits'(push.cnt) - QCntBits'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.ent[0];
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.ent[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPtrBits'(push.cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrBits'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  `MTD_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= QCntBits'(QueueDepth), "queue count overflow")
  `MTD_ASSERT(a_push_room, clk, rst_n, (push.cnt != 2'd0) |-> room, "push without room")

endmodule

### hw/rtl/morse_tone_decoder_unit.sv
// top level of the morse tone decoder
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    sample (16b signed)
//   out_ch    out   valid/ready    character (7b), last (1b)
//   apb       in    psel/penable   paddr (5b), pwdata/prdata (32b)
//
// a sample request is taken every cycle while the result queue has room for two
// a sample's results pass through the sample register and then the result queue before they are offered
// one result leaves per cycle while out_ch is ready; a two-result sample sends its results one after the other
// reset is synchronous, active low; no clearing pass
// an output stall holds the queue; input stalls while a held sample waits for two free slots
module morse_tone_decoder_unit
  import mtd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  mtd_in_if.sink              in_ch,
  mtd_out_if.source           out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready
);

  cfg_t  cfg;
  push_t push;
  logic  room;

  mtd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mtd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg),
    .room  (room),
    .push  (push)
  );

  mtd_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
